// ===== rtl/core/rgp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types and constants for the radial gradient pixel pipeline.
// ----------------------------------------------------------------------------
package rgp_pkg;

    localparam int CoordW   = 12;
    localparam int CfgDimW  = 13;
    localparam int LevelW   = 8;
    localparam int RadiusW  = 13;
    localparam int AbsW     = 13;
    localparam int SqW      = 2 * AbsW;
    localparam int DistW    = SqW + 2;
    localparam int QuotW    = LevelW;
    localparam int AddrW    = 5;
    localparam int DataW    = 32;
    localparam int RegIdxW  = 3;

    // register map, index = byte address / 4
    localparam logic [RegIdxW-1:0] RegWidth  = 3'd0;
    localparam logic [RegIdxW-1:0] RegHeight = 3'd1;
    localparam logic [RegIdxW-1:0] RegInner  = 3'd2;
    localparam logic [RegIdxW-1:0] RegOuter  = 3'd3;
    localparam logic [RegIdxW-1:0] RegRadius = 3'd4;

    typedef struct packed {
        logic [CoordW-1:0] pixel_col;
        logic [CoordW-1:0] pixel_row;
    } rgp_in_t;

    typedef struct packed {
        logic [LevelW-1:0] gray_level;
        logic              beyond_radius;
    } rgp_out_t;

    // control that travels alongside each pipeline stage
    typedef struct packed {
        logic valid;
        logic in_circle;
    } rgp_ctl_t;

endpackage

// ===== rtl/core/radial_gradient_pixel.sv =====
// Throughput: one pixel per clock; busy is never raised.
// Most of the pipeline is the square root, one root bit per pipeline stage.
// Reset clears all valid bits and loads the register defaults.
// Results cannot be stalled: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
// radial_gradient_pixel
// Gray level of a radial gradient around the image center, per pixel.
// ----------------------------------------------------------------------------
module radial_gradient_pixel
    import rgp_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // pixel transfer
    input  logic             start,
    output logic             busy,
    input  rgp_in_t          pixel,
    output logic             done,
    output rgp_out_t         result,
    // APB register port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    localparam int RootW = DistW / 2 + FRAC_BITS;

    logic [CfgDimW-1:0] width_reg;
    logic [CfgDimW-1:0] height_reg;
    logic [LevelW-1:0]  inner_reg;
    logic [LevelW-1:0]  outer_reg;
    logic [RadiusW-1:0] radius_reg;

    logic               wr_en;
    logic [RegIdxW-1:0] reg_idx;

    rgp_ctl_t           off_ctl;
    logic [DistW-1:0]   dist2;
    rgp_ctl_t           sq_ctl;
    logic [RootW-1:0]   root;
    rgp_ctl_t           div_ctl;
    logic [QuotW-1:0]   quot;

    logic               done_reg;
    rgp_out_t           result_reg;
    rgp_out_t           result_next;

    // ------------------------------------------------------------------
    // register file: a write lands on the access cycle
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CfgDimW'(256);
            height_reg <= CfgDimW'(256);
            inner_reg  <= '0;
            outer_reg  <= LevelW'(255);
            radius_reg <= RadiusW'(128);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                RegWidth:  width_reg  <= pwdata[CfgDimW-1:0];
                RegHeight: height_reg <= pwdata[CfgDimW-1:0];
                RegInner:  inner_reg  <= pwdata[LevelW-1:0];
                RegOuter:  outer_reg  <= pwdata[LevelW-1:0];
                RegRadius: radius_reg <= pwdata[RadiusW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegWidth:  prdata = DataW'(width_reg);
            RegHeight: prdata = DataW'(height_reg);
            RegInner:  prdata = DataW'(inner_reg);
            RegOuter:  prdata = DataW'(outer_reg);
            RegRadius: prdata = DataW'(radius_reg);
            default:   prdata = '0;
        endcase
    end

    // fully pipelined, a new pixel every clock
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // datapath: offsets -> square root -> scale and divide -> output
    // ------------------------------------------------------------------
    rgp_offset #(
        .MAX_DIM (MAX_DIM)
    ) u_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .pixel    (pixel),
        .width    (width_reg),
        .height   (height_reg),
        .radius   (radius_reg),
        .ctl      (off_ctl),
        .dist2    (dist2)
    );

    rgp_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (off_ctl),
        .dist2   (dist2),
        .out_ctl (sq_ctl),
        .root    (root)
    );

    rgp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (sq_ctl),
        .root    (root),
        .inner   (inner_reg),
        .outer   (outer_reg),
        .radius  (radius_reg),
        .out_ctl (div_ctl),
        .quot    (quot)
    );

    // pixels at or past the radius take the outer level; inside, the
    // quotient moves the level away from inner in the direction of outer
    always_comb
    begin
        result_next.beyond_radius = !div_ctl.in_circle;
        if (!div_ctl.in_circle)
        begin
            result_next.gray_level = outer_reg;
        end
        else if (outer_reg >= inner_reg)
        begin
            result_next.gray_level = inner_reg + quot;
        end
        else
        begin
            result_next.gray_level = inner_reg - quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_beyond_outer : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.beyond_radius |-> result.gray_level == outer_reg)
        else $error("beyond-radius pixel not at outer level");

    a_zero_radius : assert property (@(posedge clk) disable iff (!rst_n)
        done && (radius_reg == '0) |-> result.beyond_radius)
        else $error("zero radius produced an inside pixel");

    a_done_src : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(div_ctl.valid))
        else $error("done without a transfer leaving the divider");

    a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.beyond_radius && (inner_reg <= outer_reg)
        |-> (result.gray_level >= inner_reg) && (result.gray_level <= outer_reg))
        else $error("gray level outside inner..outer span");
`endif

endmodule

// ===== rtl/core/rgp_offset.sv =====
// ----------------------------------------------------------------------------
// rgp_offset
// Center offsets, squares and radius test; three register stages.
// ----------------------------------------------------------------------------
module rgp_offset
    import rgp_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rgp_in_t            pixel,
    input  logic [CfgDimW-1:0] width,
    input  logic [CfgDimW-1:0] height,
    input  logic [RadiusW-1:0] radius,
    output rgp_ctl_t           ctl,
    output logic [DistW-1:0]   dist2
);

    localparam int DimCap = (MAX_DIM > (2 ** CfgDimW - 1)) ? (2 ** CfgDimW - 1) : MAX_DIM;
    localparam int OffW   = CoordW + 3;

    logic [CfgDimW-1:0]     wc;
    logic [CfgDimW-1:0]     hc;
    logic signed [OffW-1:0] dx;
    logic signed [OffW-1:0] dy;
    logic [OffW-1:0]        adx_full;
    logic [OffW-1:0]        ady_full;

    logic               v1_reg;
    logic [AbsW-1:0]    adx_reg;
    logic [AbsW-1:0]    ady_reg;
    logic               v2_reg;
    logic [SqW-1:0]     sqx_reg;
    logic [SqW-1:0]     sqy_reg;
    logic [DistW-1:0]   lim_reg;
    logic               rz_reg;
    rgp_ctl_t           ctl_reg;
    logic [DistW-1:0]   dist2_reg;
    logic [DistW-1:0]   dist2_next;
    logic [RadiusW:0]   rad2;

    always_comb
    begin
        wc = (32'(width)  > DimCap) ? CfgDimW'(DimCap) : width;
        hc = (32'(height) > DimCap) ? CfgDimW'(DimCap) : height;
        dx = $signed({2'b00, pixel.pixel_col, 1'b0}) - $signed(OffW'(wc)) + OffW'(1);
        dy = $signed({2'b00, pixel.pixel_row, 1'b0}) - $signed(OffW'(hc)) + OffW'(1);
        adx_full = (dx < 0) ? OffW'(-dx) : OffW'(dx);
        ady_full = (dy < 0) ? OffW'(-dy) : OffW'(dy);
        rad2 = {radius, 1'b0};
        dist2_next = DistW'(sqx_reg) + DistW'(sqy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg            <= in_valid;
            v2_reg            <= v1_reg;
            ctl_reg.valid     <= v2_reg;
            ctl_reg.in_circle <= !rz_reg && (dist2_next < lim_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg   <= adx_full[AbsW-1:0];
        ady_reg   <= ady_full[AbsW-1:0];
        sqx_reg   <= adx_reg * adx_reg;
        sqy_reg   <= ady_reg * ady_reg;
        lim_reg   <= DistW'(rad2 * rad2);
        rz_reg    <= (radius == '0);
        dist2_reg <= dist2_next;
    end

    assign ctl   = ctl_reg;
    assign dist2 = dist2_reg;

endmodule

// ===== rtl/core/rgp_sqrt.sv =====
// ----------------------------------------------------------------------------
// rgp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rgp_sqrt
    import rgp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgp_ctl_t                          in_ctl,
    input  logic [DistW-1:0]                  dist2,
    output rgp_ctl_t                          out_ctl,
    output logic [DistW/2+FRAC_BITS-1:0]      root
);

    localparam int RootW = DistW / 2 + FRAC_BITS;
    localparam int RadW  = 2 * RootW;

    rgp_ctl_t         ctl_reg  [0:RootW];
    logic [RadW-1:0]  rad_reg  [0:RootW];
    logic [RootW:0]   rem_reg  [0:RootW];
    logic [RootW-1:0] root_reg [0:RootW];

    assign ctl_reg[0]  = in_ctl;
    assign rad_reg[0]  = {dist2, (2 * FRAC_BITS)'(0)};
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar k = 0; k < RootW; k++)
    begin : g_stage
        logic [RootW+2:0] trial;
        logic [RootW+1:0] cand;
        logic             ge;
        logic [RootW+2:0] diff;

        always_comb
        begin
            trial = {rem_reg[k], rad_reg[k][RadW-1 -: 2]};
            cand  = {root_reg[k], 2'b01};
            ge    = (trial >= {1'b0, cand});
            diff  = trial - {1'b0, cand};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k+1]  <= {rad_reg[k][RadW-3:0], 2'b00};
            rem_reg[k+1]  <= ge ? diff[RootW:0] : trial[RootW:0];
            root_reg[k+1] <= {root_reg[k][RootW-2:0], ge};
        end
    end

    assign out_ctl = ctl_reg[RootW];
    assign root    = root_reg[RootW];

endmodule

// ===== rtl/core/rgp_div.sv =====
// ----------------------------------------------------------------------------
// rgp_div
// Scale the root by the level span, then restoring divide, one bit per stage.
// ----------------------------------------------------------------------------
module rgp_div
    import rgp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgp_ctl_t                      in_ctl,
    input  logic [DistW/2+FRAC_BITS-1:0]  root,
    input  logic [LevelW-1:0]             inner,
    input  logic [LevelW-1:0]             outer,
    input  logic [RadiusW-1:0]            radius,
    output rgp_ctl_t                      out_ctl,
    output logic [QuotW-1:0]              quot
);

    localparam int RootW = DistW / 2 + FRAC_BITS;
    localparam int DenW  = RadiusW + 1 + FRAC_BITS;
    localparam int NumW  = RootW + LevelW + 1;

    logic              asc;
    logic [LevelW-1:0] span;
    logic [DenW-1:0]   den;
    logic [NumW-1:0]   num_next;

    rgp_ctl_t         ctl_reg [0:QuotW];
    logic [NumW-1:0]  rem_reg [0:QuotW];
    logic [QuotW-1:0] q_reg   [0:QuotW];

    always_comb
    begin
        asc      = (outer >= inner);
        span     = asc ? (outer - inner) : (inner - outer);
        den      = {radius, 1'b0, FRAC_BITS'(0)};
        num_next = NumW'(root * span);
        // rounding up when the level falls
        if (!asc)
        begin
            num_next = num_next + NumW'(den) - NumW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        q_reg[0]   <= '0;
    end

    for (genvar j = 0; j < QuotW; j++)
    begin : g_stage
        logic [NumW-1:0] shd;
        logic            ge;

        always_comb
        begin
            shd = NumW'(den) << (QuotW - 1 - j);
            ge  = (rem_reg[j] >= shd);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j+1] <= '0;
            end
            else
            begin
                ctl_reg[j+1] <= ctl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= ge ? (rem_reg[j] - shd) : rem_reg[j];
            q_reg[j+1]   <= {q_reg[j][QuotW-2:0], ge};
        end
    end

    assign out_ctl = ctl_reg[QuotW];
    assign quot    = q_reg[QuotW];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel coordinates into the radial gradient block across several
// register settings and checks every gray level against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import rgp_pkg::*;

    localparam int FracBits   = 8;
    localparam int MaxDim     = 4096;
    localparam int PipeCycles = 40;      // block latency plus margin
    localparam int CycleLimit = 400000;

    // ------------------------------------------------------------------------
    // Gray-level expectations, oldest first
    // ------------------------------------------------------------------------
    class level_scoreboard;
        rgp_out_t pending[$];
        int       errors;

        // register copy, same widths as the block
        logic [CfgDimW-1:0] width_q  = 13'd256;
        logic [CfgDimW-1:0] height_q = 13'd256;
        logic [LevelW-1:0]  inner_q  = 8'd0;
        logic [LevelW-1:0]  outer_q  = 8'd255;
        logic [RadiusW-1:0] radius_q = 13'd128;

        function void set_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
            case (idx)
                RegWidth:  width_q  = val[CfgDimW-1:0];
                RegHeight: height_q = val[CfgDimW-1:0];
                RegInner:  inner_q  = val[LevelW-1:0];
                RegOuter:  outer_q  = val[LevelW-1:0];
                RegRadius: radius_q = val[RadiusW-1:0];
                default: ;
            endcase
        endfunction

        // truncated integer root, bit by bit
        function longint unsigned int_root(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   -= res + bitv;
                    res  = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function void note_pixel(rgp_in_t px);
            longint          w, h, dx, dy;
            longint unsigned d2, r, s, den, num;
            rgp_out_t        e;
            w  = (width_q > MaxDim) ? MaxDim : width_q;
            h  = (height_q > MaxDim) ? MaxDim : height_q;
            dx = 2 * longint'(px.pixel_col) - w + 1;
            dy = 2 * longint'(px.pixel_row) - h + 1;
            d2 = dx * dx + dy * dy;
            r  = radius_q;
            if (r != 0 && d2 < 4 * r * r)
            begin
                s   = int_root(d2 << (2 * FracBits));
                den = (2 * r) << FracBits;
                e.beyond_radius = 1'b0;
                if (outer_q >= inner_q)
                begin
                    num = s * (outer_q - inner_q);
                    e.gray_level = inner_q + num / den;
                end
                else
                begin
                    num = s * (inner_q - outer_q);
                    e.gray_level = inner_q - (num + den - 1) / den;
                end
            end
            else
            begin
                e.gray_level    = outer_q;
                e.beyond_radius = 1'b1;
            end
            pending.push_back(e);
        endfunction

        function void check_level(rgp_out_t got);
            rgp_out_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.gray_level !== e.gray_level)
            begin
                $display("%0t: gray_level exp %0d got %0d", $realtime, e.gray_level,
                         got.gray_level);
                errors++;
            end
            if (got.beyond_radius !== e.beyond_radius)
            begin
                $display("%0t: beyond_radius exp %0d got %0d", $realtime,
                         e.beyond_radius, got.beyond_radius);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    rgp_in_t          pixel;
    logic             done;
    rgp_out_t         result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    level_scoreboard sb;
    int              cycles;

    radial_gradient_pixel u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results are a one-cycle strobe; sample at the edge that ends the cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_level(result);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // APB write: setup cycle, then access until pready; the bus is left
    // selected so writes can follow back to back
    task automatic reg_write(logic [RegIdxW-1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_setting(int w, int h, int inn, int outr, int rad);
        reg_write(RegWidth, w);
        reg_write(RegHeight, h);
        reg_write(RegInner, inn);
        reg_write(RegOuter, outr);
        reg_write(RegRadius, rad);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel transfer; start stays high while transfers follow back to back
    task automatic send_pixel(logic [CoordW-1:0] c, logic [CoordW-1:0] r);
        int gap;
        start       <= 1'b1;
        pixel.pixel_col <= c;
        pixel.pixel_row <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_pixel('{pixel_col: c, pixel_row: r});
        gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 9) == 0) ?
              $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for every expected transfer, then the pipeline depth
    task automatic drain();
        int n;
        start <= 1'b0;
        n = 0;
        while (sb.pending.size() != 0 && n < 10000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (PipeCycles) @(posedge clk);
    endtask

    // pixel near the image, sometimes anywhere in the field range
    task automatic random_pixels(int count, int w, int h);
        logic [CoordW-1:0] c, r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = CoordW'($urandom);
                r = CoordW'($urandom);
            end
            else
            begin
                c = CoordW'($urandom_range(0, (w > 4096 ? 4096 : (w < 1 ? 1 : w)) - 1));
                r = CoordW'($urandom_range(0, (h > 4096 ? 4096 : (h < 1 ? 1 : h)) - 1));
            end
            send_pixel(c, r);
        end
    endtask

    initial
    begin
        int w, h, rad;
        sb      = new();
        cycles  = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        pixel   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, corners, center, field extremes
        send_pixel(0, 0);
        send_pixel(127, 127);
        send_pixel(128, 128);
        send_pixel(255, 0);
        send_pixel(4095, 4095);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();

        // inner above outer, zero radius, zero and oversized dimensions
        load_setting(100, 60, 255, 0, 40);
        send_pixel(50, 30);
        send_pixel(0, 0);
        send_pixel(99, 59);
        send_pixel(70, 30);
        drain();
        load_setting(0, 8191, 17, 200, 0);
        send_pixel(0, 0);
        send_pixel(4095, 2048);
        drain();
        load_setting(8191, 0, 0, 255, 8191);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(2048, 0);
        drain();
        load_setting(1, 1, 200, 200, 1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        drain();

        // random settings, mostly small images
        for (int phase = 0; phase < 10; phase++)
        begin
            w   = (phase == 9) ? 4096 : $urandom_range(1, 300);
            h   = (phase == 9) ? 4096 : $urandom_range(1, 300);
            rad = (phase % 4 == 3) ? $urandom_range(0, 8191) :
                  $urandom_range(1, (w > h ? w : h));
            load_setting(w, h, $urandom_range(0, 255), $urandom_range(0, 255), rad);
            random_pixels(200, w, h);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
